@@ hdl/mt19937_packed_draw_assert.svh @@
// ----------------------------------------------------------------------------
// mt19937_packed_draw assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MT19937_PACKED_DRAW_ASSERT_SVH
`define MT19937_PACKED_DRAW_ASSERT_SVH

// Same-cycle implication.
`define MTPD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtpd_pkg
// Constants and sequencer states shared by the packed MT19937 draw block.
// ----------------------------------------------------------------------------
package mtpd_pkg;

  localparam int unsigned Words  = 624;
  localparam int unsigned Shift  = 397;
  localparam int unsigned Draws  = 6;
  localparam int unsigned PosMax = Words - Draws - Shift;

  localparam logic [31:0] InitMul  = 32'd1812433253;
  localparam logic [31:0] LcgMulLo = 32'h6C07_8965;
  localparam logic [31:0] LcgMulHi = 32'h5D58_8B65;
  localparam logic [31:0] LcgAdd   = 32'h0026_9EC3;
  localparam logic [31:0] Matrix   = 32'h9908_B0DF;
  localparam logic [31:0] Upper    = 32'h8000_0000;
  localparam logic [31:0] Lower    = 32'h7FFF_FFFF;
  localparam logic [31:0] TemperB  = 32'h9D2C_5680;
  localparam logic [31:0] TemperC  = 32'hEFC6_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG,
    S_INIT,
    S_TWIST,
    S_OUT
  } state_e;

endpackage

@@ hdl/mtpd_mul.sv @@
// ----------------------------------------------------------------------------
// mtpd_mul
// Shared 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mtpd_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_d;
  logic [63:0] prod_q;

  assign prod_d = {32'd0, a_i} * {32'd0, b_i};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/mtpd_twist.sv @@
// ----------------------------------------------------------------------------
// mtpd_twist
// One twist step on three state words, tempered, top five bits kept.
// ----------------------------------------------------------------------------
module mtpd_twist (
  input  logic [31:0] cur_i,
  input  logic [31:0] nxt_i,
  input  logic [31:0] far_i,
  output logic [4:0]  draw_o
);

  logic [31:0] x;
  logic [31:0] xa;
  logic [31:0] y0;
  logic [31:0] y1;
  logic [31:0] y2;
  logic [31:0] y3;
  logic [31:0] y4;

  always_comb begin
    x  = (cur_i & mtpd_pkg::Upper) | (nxt_i & mtpd_pkg::Lower);
    xa = (x >> 1) ^ (x[0] ? mtpd_pkg::Matrix : 32'd0);
    y0 = far_i ^ xa;
    // temper
    y1 = y0 ^ (y0 >> 11);
    y2 = y1 ^ ((y1 << 7) & mtpd_pkg::TemperB);
    y3 = y2 ^ ((y2 << 15) & mtpd_pkg::TemperC);
    y4 = y3 ^ (y3 >> 18);
  end

  assign draw_o = y4[31:27];

endmodule

@@ hdl/mt19937_packed_draw.sv @@
// Input transfer to valid result: optional LCG step (opcode 1), state initialisation
// up to word position+402, six twist steps; an out-of-range position goes straight
// to the result. One item at a time: input is not ready until the result is taken.
// The state initialisation runs one step a cycle through the multiplier.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle; no clearing pass.
// ----------------------------------------------------------------------------
// mt19937_packed_draw
// Six 5-bit MT19937 draws from a 64-bit seed, packed into a 30-bit code.
// ----------------------------------------------------------------------------
`include "mt19937_packed_draw_assert.svh"

module mt19937_packed_draw (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // [63:0] seed, [73:64] position, [79:74] zero
  input  logic        s_axis_tuser,  // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [29:0] packed_code, [31:30] zero
  output logic        m_axis_tuser   // [0] error
);

  localparam int unsigned LoN = mtpd_pkg::Draws + 1;
  localparam int unsigned HiN = mtpd_pkg::Draws;

  mtpd_pkg::state_e state_q, state_d;

  // Payload and sequencing registers
  logic [63:0] seed_q;
  logic [9:0]  pos_q;
  logic [31:0] acc_q;          // seed upper word, after the optional LCG step
  logic [1:0]  cnt_q;          // LCG partial-product step
  logic [9:0]  idx_q;          // index of the word produced this cycle
  logic        first_q;
  logic [31:0] lo_q [LoN];     // words position .. position+6
  logic [31:0] hi_q [HiN];     // words position+397 .. position+402
  logic [2:0]  k_q;
  logic [29:0] code_q;
  logic        err_q;

  logic        in_xfer;
  logic        out_xfer;
  logic [9:0]  in_pos;
  logic        pos_bad;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] cur_word;
  logic [31:0] cur_mix;
  logic [9:0]  last_idx;
  logic [9:0]  diff;
  logic [9:0]  hi_diff;
  logic        lo_hit;
  logic        hi_hit;
  logic [32:0] lcg_low;
  logic [4:0]  draw;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign in_pos   = s_axis_tdata[73:64];
  assign pos_bad  = in_pos > 10'(mtpd_pkg::PosMax);

  // Current state word: the seed word first, then the recurrence output.
  assign cur_word = first_q ? acc_q : (prod[31:0] + {22'd0, idx_q});
  assign cur_mix  = cur_word ^ (cur_word >> 30);
  assign last_idx = pos_q + 10'(mtpd_pkg::Shift + mtpd_pkg::Draws - 1);

  // Capture windows for the words the twist reads
  assign diff    = idx_q - pos_q;
  assign hi_diff = diff - 10'(mtpd_pkg::Shift);
  assign lo_hit  = (idx_q >= pos_q) && (diff < 10'(LoN));
  assign hi_hit  = (idx_q >= pos_q) && (diff >= 10'(mtpd_pkg::Shift))
                   && (hi_diff < 10'(HiN));

  // Carry of the additive constant into the upper word
  assign lcg_low = {1'b0, prod[31:0]} + {1'b0, mtpd_pkg::LcgAdd};

  // Shared multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      mtpd_pkg::S_LCG: begin
        case (cnt_q)
          2'd0: begin
            mul_a = seed_q[31:0];
            mul_b = mtpd_pkg::LcgMulLo;
          end
          2'd1: begin
            mul_a = seed_q[63:32];
            mul_b = mtpd_pkg::LcgMulLo;
          end
          2'd2: begin
            mul_a = seed_q[31:0];
            mul_b = mtpd_pkg::LcgMulHi;
          end
          default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
          end
        endcase
      end
      mtpd_pkg::S_INIT: begin
        mul_a = cur_mix;
        mul_b = mtpd_pkg::InitMul;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  mtpd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mtpd_twist u_twist (
    .cur_i  (lo_q[0]),
    .nxt_i  (lo_q[1]),
    .far_i  (hi_q[0]),
    .draw_o (draw)
  );

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtpd_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (pos_bad) begin
            state_d = mtpd_pkg::S_OUT;
          end else if (s_axis_tuser) begin
            state_d = mtpd_pkg::S_LCG;
          end else begin
            state_d = mtpd_pkg::S_INIT;
          end
        end
      end
      mtpd_pkg::S_LCG: begin
        if (cnt_q == 2'd3) begin
          state_d = mtpd_pkg::S_INIT;
        end
      end
      mtpd_pkg::S_INIT: begin
        if (idx_q == last_idx) begin
          state_d = mtpd_pkg::S_TWIST;
        end
      end
      mtpd_pkg::S_TWIST: begin
        if (k_q == 3'(mtpd_pkg::Draws - 1)) begin
          state_d = mtpd_pkg::S_OUT;
        end
      end
      mtpd_pkg::S_OUT: begin
        if (out_xfer) begin
          state_d = mtpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mtpd_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      mtpd_pkg::S_IDLE: s_axis_tready = 1'b1;
      mtpd_pkg::S_OUT:  m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, code_q};
  assign m_axis_tuser = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtpd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      mtpd_pkg::S_IDLE: begin
        if (in_xfer) begin
          seed_q  <= s_axis_tdata[63:0];
          pos_q   <= in_pos;
          acc_q   <= s_axis_tdata[63:32];
          cnt_q   <= 2'd0;
          idx_q   <= 10'd0;
          first_q <= 1'b1;
          k_q     <= 3'd0;
          code_q  <= 30'd0;
          err_q   <= pos_bad;
        end
      end
      mtpd_pkg::S_LCG: begin
        // Accumulate the upper word of seed * multiplier + constant
        case (cnt_q)
          2'd1:    acc_q <= prod[63:32] + {31'd0, lcg_low[32]};
          2'd2:    acc_q <= acc_q + prod[31:0];
          2'd3:    acc_q <= acc_q + prod[31:0];
          default: acc_q <= acc_q;
        endcase
        cnt_q <= cnt_q + 2'd1;
      end
      mtpd_pkg::S_INIT: begin
        // Hold only the words the twist reads
        if (lo_hit) begin
          lo_q[diff[2:0]] <= cur_word;
        end
        if (hi_hit) begin
          hi_q[hi_diff[2:0]] <= cur_word;
        end
        first_q <= 1'b0;
        idx_q   <= idx_q + 10'd1;
      end
      mtpd_pkg::S_TWIST: begin
        // Advance both windows by one word; the newest draw enters at the top
        for (int i = 0; i < LoN - 1; i++) begin
          lo_q[i] <= lo_q[i + 1];
        end
        for (int i = 0; i < HiN - 1; i++) begin
          hi_q[i] <= hi_q[i + 1];
        end
        code_q <= {draw, code_q[29:5]};
        k_q    <= k_q + 3'd1;
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  // Checks
  `MTPD_ASSERT_IMPLIES(a_one_item, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `MTPD_ASSERT_IMPLIES(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0, "error with nonzero code")
  `MTPD_ASSERT_IMPLIES(a_init_bound, state_q == mtpd_pkg::S_INIT, idx_q <= last_idx, "init ran past last word")
  `MTPD_ASSERT_NEXT(a_busy_after, in_xfer, !s_axis_tready, "ready right after a transfer")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - packed MT19937 draw block
// Drives seeds, opcodes and start positions over the input stream with random
// gaps, stalls the result stream at random, and checks every result against a
// behavioural model of the LCG step, seeding, twist and tempering.
// ----------------------------------------------------------------------------
module tb;

  // Independent model constants
  localparam int unsigned MtWords   = 624;
  localparam int unsigned MtShift   = 397;
  localparam int unsigned MtDraws   = 6;
  localparam int unsigned MtPosLast = MtWords - MtDraws - MtShift;  // 221
  localparam logic [31:0] SeedMul   = 32'd1812433253;
  localparam logic [63:0] LcgMul    = 64'h5D58_8B65_6C07_8965;
  localparam logic [63:0] LcgInc    = 64'h0000_0000_0026_9EC3;
  localparam logic [31:0] TwistXor  = 32'h9908_B0DF;
  localparam logic [31:0] TemperB   = 32'h9D2C_5680;
  localparam logic [31:0] TemperC   = 32'hEFC6_0000;

  // At least the longest busy time of one item, used for the settle time at the end
  localparam int unsigned SettleCycles = 640;
  // Watchdog limit, with a wide margin over the slowest correct run
  localparam int unsigned CycleLimit   = 6_000_000;
  localparam int unsigned RandomDraws  = 930;

  typedef struct packed {
    logic        err;
    logic [29:0] code;
  } draw_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;  // [63:0] seed, [73:64] position, [79:74] zero
  logic        s_axis_tuser  = 1'b0;  // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [29:0] packed_code, [31:30] zero
  logic        m_axis_tuser;  // [0] error

  draw_t       pending_draws[$];
  draw_t       oldest_draw;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          steady     = 1'b0;  // no gaps and no stalls while set

  mt19937_packed_draw dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected code for one request: optional LCG step, partial seeding of the
  // word array, then six twisted and tempered words, top five bits of each.
  function automatic draw_t predict_draw(input logic [63:0] seed, input logic op,
                                         input logic [9:0] pos);
    logic [31:0] words [0:MtWords-1];
    logic [63:0] s;
    logic [31:0] prev;
    logic [31:0] mixed;
    logic [31:0] y;
    int unsigned span;
    int unsigned j;
    draw_t       res;
    res = '0;
    if (pos > MtPosLast) begin
      res.err = 1'b1;
      return res;
    end
    s = seed;
    if (op) begin
      s = s * LcgMul + LcgInc;
    end
    span = pos + MtDraws + MtShift;
    words[0] = s[63:32];
    for (int unsigned i = 1; i < span; i++) begin
      prev     = words[i-1];
      words[i] = SeedMul * (prev ^ (prev >> 30)) + i;
    end
    for (int unsigned k = 0; k < MtDraws; k++) begin
      j     = pos + k;
      mixed = {words[j][31], words[j+1][30:0]};
      y     = (mixed >> 1) ^ (mixed[0] ? TwistXor : 32'd0);
      y     = words[j+MtShift] ^ y;
      y     = y ^ (y >> 11);
      y     = y ^ ((y << 7) & TemperB);
      y     = y ^ ((y << 15) & TemperC);
      y     = y ^ (y >> 18);
      res.code[5*k +: 5] = y[31:27];
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long enough to cover
  // any phase of the block's work.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 700);
  endfunction

  // Present one request, hold it until the transfer, then queue its result.
  // Valid stays high after the transfer so that a back-to-back item does not
  // lower and raise it in the same step.
  task automatic send_draw(input logic [63:0] seed, input logic op, input logic [9:0] pos);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, pos, seed};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_draws.push_back(predict_draw(seed, op, pos));
  endtask

  // Drop valid once a test has sent its last item.
  task automatic park_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Seeds at the edges of the 64-bit range, both opcodes
  task automatic test_seed_extremes();
    send_draw(64'd0, 1'b0, 10'd0);
    send_draw(64'd0, 1'b1, 10'd0);
    send_draw('1, 1'b0, 10'd0);
    send_draw('1, 1'b1, 10'd0);
    send_draw(64'h0000_0000_FFFF_FFFF, 1'b0, 10'd5);
    send_draw(64'h0000_0000_FFFF_FFFF, 1'b1, 10'd5);
    send_draw(64'hFFFF_FFFF_0000_0000, 1'b0, 10'd5);
    send_draw(64'h8000_0000_0000_0001, 1'b1, 10'd100);
    send_draw(64'h5A5A_A5A5_3C3C_C3C3, 1'b0, 10'd100);
    park_input();
  endtask

  // Start positions around the last valid one and out of range
  task automatic test_position_bounds();
    send_draw(64'h0123_4567_89AB_CDEF, 1'b0, 10'd1);
    send_draw(64'h0123_4567_89AB_CDEF, 1'b0, 10'(MtPosLast - 1));
    send_draw(64'h0123_4567_89AB_CDEF, 1'b0, 10'(MtPosLast));
    send_draw(64'hFEDC_BA98_7654_3210, 1'b1, 10'(MtPosLast));
    send_draw(64'hFEDC_BA98_7654_3210, 1'b0, 10'(MtPosLast + 1));
    send_draw(64'hFEDC_BA98_7654_3210, 1'b1, 10'(MtPosLast + 2));
    send_draw('1, 1'b1, 10'd512);
    send_draw('1, 1'b1, 10'd1023);
    send_draw(64'd0, 1'b0, 10'd1023);
    send_draw(64'd0, 1'b0, 10'd0);
    park_input();
  endtask

  // Random seeds and opcodes; positions mostly small and valid, with the
  // bounds and out-of-range values mixed in. The first stretch runs without
  // any gaps or stalls.
  task automatic test_random_draws();
    logic [63:0] seed;
    logic [9:0]  pos;
    int unsigned r;
    steady = 1'b1;
    for (int unsigned n = 0; n < RandomDraws; n++) begin
      if (n == 100) steady = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 5) seed = '0;
      else if (r < 10) seed = '1;
      else seed = {$urandom(), $urandom()};
      r = $urandom_range(0, 99);
      if (r < 40) pos = 10'($urandom_range(0, 31));
      else if (r < 70) pos = 10'($urandom_range(0, MtPosLast));
      else if (r < 78) pos = ($urandom_range(0, 1) != 0) ? 10'(MtPosLast) : 10'(MtPosLast + 1);
      else pos = 10'($urandom_range(MtPosLast + 1, 1023));
      send_draw(seed, 1'($urandom_range(0, 1)), pos);
    end
    park_input();
  endtask

  // Result side back-pressure: random ready level held for a random time
  always @(posedge clk_i) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
      stall_left    <= pick_gap();
    end
  end

  // Compare each result transfer with the oldest queued prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        $error("result with none pending: packed_code %h error %b",
               m_axis_tdata[29:0], m_axis_tuser);
        mismatches++;
      end else begin
        oldest_draw = pending_draws.pop_front();
        if (m_axis_tdata[29:0] !== oldest_draw.code) begin
          $error("packed_code: expected %h, actual %h", oldest_draw.code,
                 m_axis_tdata[29:0]);
          mismatches++;
        end
        if (m_axis_tuser !== oldest_draw.err) begin
          $error("error: expected %b, actual %b", oldest_draw.err, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_seed_extremes();
    test_position_bounds();
    test_random_draws();
    while (pending_draws.size() != 0) @(posedge clk_i);
    // Hold a while longer to catch any stray result
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ mt19937_packed_draw.f @@
+incdir+hdl
hdl/mtpd_pkg.sv
hdl/mtpd_mul.sv
hdl/mtpd_twist.sv
hdl/mt19937_packed_draw.sv
test/tb.sv
